### rtl/core/rbst_pkg.sv
// Package with the types, register codes and arithmetic helpers of the ray box slab test.
`default_nettype none
package rbst_pkg;

    localparam int QBITS      = 33;
    localparam int NUM_STAGES = QBITS;
    localparam int NUM_LANES  = 6;
    localparam int NUM_AXES   = 3;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef enum logic [2:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [32:0] num_lo;
        logic [32:0] quo;
        logic [31:0] den;
        logic        neg;
        logic        ovf;
    } div_lane_t;

    typedef struct packed {
        logic zero_dir;
        logic in_slab;
    } axis_flag_t;

    function automatic div_lane_t div_prep(logic signed [31:0] bound, logic signed [31:0] org,
                                           logic signed [31:0] dir);
        logic [32:0] diff;
        logic [32:0] mag;
        logic [31:0] dmag;
        logic [48:0] n;
        div_lane_t   l;
        diff = {bound[31], bound} - {org[31], org};
        mag  = diff[32] ? (~diff + 33'd1) : diff;
        dmag = dir[31] ? (~dir + 32'd1) : dir;
        n    = {mag, 16'd0};
        l.rem    = {16'd0, n[48:33]};
        l.num_lo = n[32:0];
        l.quo    = '0;
        l.den    = dmag;
        l.neg    = diff[32] ^ dir[31];
        l.ovf    = ({16'd0, n[48:33]} >= dmag);
        return l;
    endfunction

    function automatic logic signed [31:0] sat_q(div_lane_t l);
        logic [32:0] negq;
        negq = ~l.quo + 33'd1;
        if (l.neg) begin
            if (l.ovf || (l.quo > 33'h0_8000_0000)) begin
                return Q_MIN;
            end
            return negq[31:0];
        end
        if (l.ovf || l.quo[32] || l.quo[31]) begin
            return Q_MAX;
        end
        return l.quo[31:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/rbst_div_cell.sv
// One restoring division cell that produces one quotient bit per clock while en is high.
`default_nettype none
module rbst_div_cell
    import rbst_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      en,
    input  wire div_lane_t din,
    output div_lane_t      dout
);

    div_lane_t   lane_reg;
    div_lane_t   lane_next;
    logic [32:0] part;
    logic [32:0] diff;
    logic        qbit;

    always_comb
    begin
        part = {din.rem, din.num_lo[32]};
        diff = part - {1'b0, din.den};
        qbit = (part >= {1'b0, din.den});
        lane_next        = din;
        lane_next.rem    = qbit ? diff[31:0] : part[31:0];
        lane_next.num_lo = {din.num_lo[31:0], 1'b0};
        lane_next.quo    = {din.quo[31:0], qbit};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg <= lane_next;
        end
    end

    assign dout = lane_reg;

endmodule
`default_nettype wire

### rtl/core/rbst_merge.sv
// Saturation, ordering and interval intersection of the six quotients into a hit flag.
`default_nettype none
module rbst_merge
    import rbst_pkg::*;
(
    input  wire div_lane_t  lanes [NUM_LANES],
    input  wire axis_flag_t flags [NUM_AXES],
    output logic            hit
);

    logic signed [31:0] t0 [NUM_AXES];
    logic signed [31:0] t1 [NUM_AXES];
    logic               ok [NUM_AXES];
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] lo_xy;
    logic signed [31:0] hi_xy;
    logic               hit_xy;

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            a = sat_q(lanes[k]);
            b = sat_q(lanes[k + NUM_AXES]);
            if (flags[k].zero_dir)
            begin
                t0[k] = Q_MIN;
                t1[k] = Q_MAX;
                ok[k] = flags[k].in_slab;
            end
            else
            begin
                t0[k] = (a > b) ? b : a;
                t1[k] = (a > b) ? a : b;
                ok[k] = 1'b1;
            end
        end
        hit_xy = ok[0] && ok[1] && !((t0[0] > t1[1]) || (t0[1] > t1[0]));
        lo_xy  = (t0[1] > t0[0]) ? t0[1] : t0[0];
        hi_xy  = (t1[1] < t1[0]) ? t1[1] : t1[0];
        hit    = hit_xy && ok[2] && !((lo_xy > t1[2]) || (t0[2] > hi_xy));
    end

endmodule
`default_nettype wire

### rtl/core/ray_box_slab_test.sv
// Top level of the ray box slab test: box registers, division cell chain and result register.
//
// Channel   Signals                                   Direction
// config    cfg_valid cfg_ready cfg_index cfg_data     in
// ray       in_valid in_ready ray_origin_* ray_dir_*   in
// result    out_valid out_ready hit                    out
//
// One ray word is accepted per cycle while in_ready is high.
// Its hit word runs through the 33 division cells, one quotient bit each, and the result register.
// Reset clears the box registers and all valid flags; the config port is always ready.
// When the result word is stalled, the whole chain holds and in_ready drops.
`default_nettype none
module ray_box_slab_test
    import rbst_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] ray_origin_x,
    input  wire logic signed [31:0] ray_origin_y,
    input  wire logic signed [31:0] ray_origin_z,
    input  wire logic signed [31:0] ray_dir_x,
    input  wire logic signed [31:0] ray_dir_y,
    input  wire logic signed [31:0] ray_dir_z,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    hit
);

    logic signed [31:0] box_reg [NUM_LANES];
    logic               valid_reg [NUM_STAGES];
    axis_flag_t         flag_reg [NUM_STAGES][NUM_AXES];
    axis_flag_t         flag_next [NUM_AXES];
    div_lane_t          prep [NUM_LANES];
    div_lane_t          cell_q [NUM_LANES][NUM_STAGES];
    div_lane_t          last_q [NUM_LANES];
    logic signed [31:0] org [NUM_AXES];
    logic signed [31:0] dir [NUM_AXES];
    logic               out_valid_reg;
    logic               hit_reg;
    logic               hit_next;
    logic               en;

    assign cfg_ready = 1'b1;
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;

    assign org[0] = ray_origin_x;
    assign org[1] = ray_origin_y;
    assign org[2] = ray_origin_z;
    assign dir[0] = ray_dir_x;
    assign dir[1] = ray_dir_y;
    assign dir[2] = ray_dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                box_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_X: box_reg[0] <= cfg_data;
                REG_MIN_Y: box_reg[1] <= cfg_data;
                REG_MIN_Z: box_reg[2] <= cfg_data;
                REG_MAX_X: box_reg[3] <= cfg_data;
                REG_MAX_Y: box_reg[4] <= cfg_data;
                REG_MAX_Z: box_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            flag_next[k].zero_dir = (dir[k] == 32'sd0);
            flag_next[k].in_slab  = (org[k] >= box_reg[k]) && (org[k] <= box_reg[k + NUM_AXES]);
            prep[k]            = div_prep(box_reg[k], org[k], dir[k]);
            prep[k + NUM_AXES] = div_prep(box_reg[k + NUM_AXES], org[k], dir[k]);
        end
    end

    for (genvar ln = 0; ln < NUM_LANES; ln++)
    begin : g_lane
        for (genvar st = 0; st < NUM_STAGES; st++)
        begin : g_stage
            if (st == 0)
            begin : g_first
                rbst_div_cell u_cell (
                    .clk  (clk),
                    .en   (en),
                    .din  (prep[ln]),
                    .dout (cell_q[ln][st])
                );
            end
            else
            begin : g_next
                rbst_div_cell u_cell (
                    .clk  (clk),
                    .en   (en),
                    .din  (cell_q[ln][st - 1]),
                    .dout (cell_q[ln][st])
                );
            end
        end
        assign last_q[ln] = cell_q[ln][NUM_STAGES - 1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                valid_reg[s] <= valid_reg[s - 1];
            end
            out_valid_reg <= valid_reg[NUM_STAGES - 1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flag_reg[0] <= flag_next;
            for (int s = 1; s < NUM_STAGES; s++)
            begin
                flag_reg[s] <= flag_reg[s - 1];
            end
            hit_reg <= hit_next;
        end
    end

    rbst_merge u_merge (
        .lanes (last_q),
        .flags (flag_reg[NUM_STAGES - 1]),
        .hit   (hit_next)
    );

endmodule
`default_nettype wire
